// ----- rtl/klc_pkg.sv -----
// Package for the keypad lock controller.
// Holds mode and event codes, configuration indexes and reset values.
// No dependencies.
package klc_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_GRANTED = 2'd1,
    MODE_LOCKED  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_DIGIT        = 3'd1,
    EV_WRONG        = 3'd2,
    EV_GRANTED      = 3'd3,
    EV_WRONG_LOCKED = 3'd4,
    EV_RESET        = 3'd5
  } event_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSWORD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKED_HALF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANTED_HALF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANTED_BLNK = 3'd4;

  localparam logic [15:0] RST_PASSWORD     = 16'h1234;
  localparam logic [3:0]  RST_MAX_FAILURES = 4'd3;
  localparam logic [7:0]  RST_LOCKED_HALF  = 8'd50;
  localparam logic [7:0]  RST_GRANTED_HALF = 8'd30;
  localparam logic [2:0]  RST_GRANTED_BLNK = 3'd3;

  // reset word "forgot"
  localparam int WORD_LEN = 6;
  localparam logic [7:0] WORD_LETTERS [WORD_LEN] = '{8'h66, 8'h6f, 8'h72, 8'h67, 8'h6f, 8'h74};
  localparam logic [2:0] WORD_LAST = 3'd5;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_CASE    = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

endpackage

// ----- rtl/keypad_lock_controller_core.sv -----
// Keypad lock controller top level: input register, one pass of lock logic,
// result register. Depends on klc_pkg.
// The input transaction is captured in the input register, and its result is loaded into the result register.
// Throughput: one transaction per cycle; the result register is the only stall point.
// Reset (rst_n low, synchronous): mode idle, failure count, entry and word match
// cleared, LED off; configuration returns to its default values.
module keypad_lock_controller_core #(
  parameter int CODE_DIGITS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [7:0]                     in_char_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_event_res,
  output logic [1:0]                     out_mode,
  output logic                           out_led_on,
  output logic [3:0]                     out_failure_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [klc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);
  import klc_pkg::*;

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_DIGITS - 1);

  logic [15:0] password_r;
  logic [3:0]  max_failures_r;
  logic [7:0]  locked_half_r;
  logic [7:0]  granted_half_r;
  logic [2:0]  granted_blinks_r;

  logic        in_vld_r;
  logic        in_action_r;
  logic [7:0]  in_char_r;
  logic        advance;

  mode_t       mode_r, mode_nxt;
  logic [3:0]  failures_r, failures_nxt;
  logic [3:0]  digit_store_r [CODE_DIGITS];
  logic [CNT_W-1:0] digit_count_r, digit_count_nxt;
  logic [2:0]  word_pos_r, word_pos_nxt;
  logic [7:0]  led_timer_r, led_timer_nxt;
  logic        led_r, led_nxt;
  logic [2:0]  blinks_r, blinks_nxt;
  event_t      event_nxt;

  logic        out_valid_r;
  event_t      out_event_r;
  mode_t       out_mode_r;
  logic        out_led_r;
  logic [3:0]  out_failures_r;

  logic [7:0]  ch;
  logic [3:0]  digit;
  logic        is_digit;
  logic        word_hit;
  logic        store_en;
  logic        match;
  logic [3:0]  exp_digit;
  logic [3:0]  fail_inc;
  logic [7:0]  timer_inc;
  logic [7:0]  half_sel;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      password_r       <= RST_PASSWORD;
      max_failures_r   <= RST_MAX_FAILURES;
      locked_half_r    <= RST_LOCKED_HALF;
      granted_half_r   <= RST_GRANTED_HALF;
      granted_blinks_r <= RST_GRANTED_BLNK;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PASSWORD:     password_r       <= cfg_data;
        CFG_MAX_FAILURES: max_failures_r   <= cfg_data[3:0];
        CFG_LOCKED_HALF:  locked_half_r    <= cfg_data[7:0];
        CFG_GRANTED_HALF: granted_half_r   <= cfg_data[7:0];
        CFG_GRANTED_BLNK: granted_blinks_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_action_r <= in_action;
      in_char_r   <= in_char_code;
    end
  end

  // character decode
  always_comb begin
    ch = in_char_r;
    if (in_char_r >= CH_UPPER_A && in_char_r <= CH_UPPER_Z) begin
      ch = in_char_r + CH_CASE;
    end
    is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    digit     = 4'(ch - CH_ZERO);
    word_hit  = (word_pos_r <= WORD_LAST) && (ch == WORD_LETTERS[word_pos_r]);
    fail_inc  = (failures_r == 4'hf) ? failures_r : failures_r + 4'd1;
  end

  // code compare: stored digits plus the digit arriving now as the last one
  always_comb begin
    match     = 1'b1;
    exp_digit = '0;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (CODE_DIGITS - 1 - i >= 4) begin
        exp_digit = '0;
      end else begin
        exp_digit = password_r[4*(CODE_DIGITS-1-i) +: 4];
      end
      if (i == CODE_DIGITS - 1) begin
        if (digit != exp_digit) match = 1'b0;
      end else begin
        if (digit_store_r[i] != exp_digit) match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    failures_nxt    = failures_r;
    digit_count_nxt = digit_count_r;
    word_pos_nxt    = word_pos_r;
    led_timer_nxt   = led_timer_r;
    led_nxt         = led_r;
    blinks_nxt      = blinks_r;
    event_nxt       = EV_NONE;
    store_en        = 1'b0;
    half_sel        = (mode_r == MODE_LOCKED) ? locked_half_r : granted_half_r;
    timer_inc       = (led_timer_r == 8'hff) ? led_timer_r : led_timer_r + 8'd1;

    if (in_action_r) begin
      unique case (mode_r)
        MODE_LOCKED: begin
          if (timer_inc >= half_sel) begin
            led_timer_nxt = '0;
            led_nxt       = !led_r;
          end else begin
            led_timer_nxt = timer_inc;
          end
        end
        MODE_GRANTED: begin
          if (blinks_r >= granted_blinks_r) begin
            led_nxt = 1'b1;
          end else if (timer_inc >= half_sel) begin
            led_timer_nxt = '0;
            if (led_r) begin
              led_nxt = 1'b0;
            end else begin
              led_nxt    = 1'b1;
              blinks_nxt = blinks_r + 3'd1;
            end
          end else begin
            led_timer_nxt = timer_inc;
          end
        end
        default: begin
          led_nxt = 1'b0;
        end
      endcase
    end else if (mode_r != MODE_GRANTED) begin
      if (word_hit) begin
        if (word_pos_r == WORD_LAST) begin
          word_pos_nxt    = '0;
          failures_nxt    = '0;
          mode_nxt        = MODE_IDLE;
          digit_count_nxt = '0;
          led_nxt         = 1'b0;
          led_timer_nxt   = '0;
          blinks_nxt      = '0;
          event_nxt       = EV_RESET;
        end else begin
          word_pos_nxt = word_pos_r + 3'd1;
        end
      end else begin
        word_pos_nxt = '0;
        if (mode_r != MODE_LOCKED && is_digit) begin
          if (digit_count_r != CNT_LAST) begin
            store_en        = 1'b1;
            digit_count_nxt = digit_count_r + CNT_W'(1);
            event_nxt       = EV_DIGIT;
          end else begin
            digit_count_nxt = '0;
            if (match) begin
              mode_nxt      = MODE_GRANTED;
              led_nxt       = 1'b1;
              led_timer_nxt = '0;
              blinks_nxt    = '0;
              event_nxt     = EV_GRANTED;
            end else begin
              failures_nxt = fail_inc;
              if (fail_inc >= max_failures_r) begin
                mode_nxt      = MODE_LOCKED;
                led_nxt       = 1'b1;
                led_timer_nxt = '0;
                blinks_nxt    = '0;
                event_nxt     = EV_WRONG_LOCKED;
              end else begin
                event_nxt = EV_WRONG;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      failures_r    <= '0;
      digit_count_r <= '0;
      word_pos_r    <= '0;
      led_timer_r   <= '0;
      led_r         <= 1'b0;
      blinks_r      <= '0;
    end else if (advance) begin
      mode_r        <= mode_nxt;
      failures_r    <= failures_nxt;
      digit_count_r <= digit_count_nxt;
      word_pos_r    <= word_pos_nxt;
      led_timer_r   <= led_timer_nxt;
      led_r         <= led_nxt;
      blinks_r      <= blinks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store_en) begin
      digit_store_r[digit_count_r[IDX_W-1:0]] <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r    <= event_nxt;
      out_mode_r     <= mode_nxt;
      out_led_r      <= led_nxt;
      out_failures_r <= failures_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_event_r;
  assign out_mode          = out_mode_r;
  assign out_led_on        = out_led_r;
  assign out_failure_count = out_failures_r;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for keypad_lock_controller_core: reset word, code entry,
// lockout and LED blink behavior checked against an in-bench lock predictor.
// Depends on klc_pkg and the keypad_lock_controller_core RTL.
module tb;
  import klc_pkg::*;

  localparam int DIGITS = 4;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_PRINTS = 200;
  localparam logic [47:0] FORGOT_TEXT = "forgot";

  typedef struct packed {
    logic       action;
    logic [7:0] code;
  } key_item_t;

  typedef struct packed {
    event_t     ev;
    mode_t      mode;
    logic       led;
    logic [3:0] fails;
  } lock_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_action;
  logic [7:0]           in_char_code;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_event_res;
  logic [1:0]           out_mode;
  logic                 out_led_on;
  logic [3:0]           out_failure_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  keypad_lock_controller_core #(.CODE_DIGITS(DIGITS)) DUT (.*);

  // stimulus and scoreboard
  key_item_t    key_q[$];
  lock_result_t expected_q[$];
  key_item_t    next_key;
  lock_result_t want;
  logic         item_taken;
  logic         cfg_taken;
  int           gap_pct;
  int           stall_pct;
  int           items_queued;
  int           items_sent;
  int           results_checked;
  int           cfg_writes;
  int           err_count;
  int           stuck_cycles;
  int           grants_seen;
  int           lockouts_seen;
  int           wrongs_seen;
  int           resets_seen;

  // lock predictor state and configuration
  mode_t       cur_mode;
  logic [3:0]  fail_cnt;
  logic [3:0]  entry [DIGITS];
  int          entry_len;
  int          word_idx;
  logic [7:0]  led_tmr;
  logic        led_lvl;
  logic [2:0]  blink_cnt;
  logic [15:0] pw_cfg;
  logic [3:0]  max_fail_cfg;
  logic [7:0]  lock_half_cfg;
  logic [7:0]  grant_half_cfg;
  logic [2:0]  grant_blinks_cfg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void led_restart(input logic level);
    led_lvl = level;
    led_tmr = 8'd0;
    blink_cnt = 3'd0;
  endfunction

  function automatic logic led_half_done(input logic [7:0] half);
    if (led_tmr != 8'hff) led_tmr++;
    if (led_tmr >= half) begin
      led_tmr = 8'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void led_tick();
    case (cur_mode)
      MODE_LOCKED: begin
        if (led_half_done(lock_half_cfg)) led_lvl = ~led_lvl;
      end
      MODE_GRANTED: begin
        if (blink_cnt >= grant_blinks_cfg) begin
          led_lvl = 1'b1;
        end else if (led_half_done(grant_half_cfg)) begin
          if (led_lvl) begin
            led_lvl = 1'b0;
          end else begin
            blink_cnt++;
            led_lvl = 1'b1;
          end
        end
      end
      default: led_lvl = 1'b0;
    endcase
  endfunction

  function automatic logic [3:0] pw_digit(input int i);
    int n;
    n = DIGITS - 1 - i;
    if (n >= 4) return 4'd0;
    return pw_cfg[4*n +: 4];
  endfunction

  function automatic event_t take_char(input logic [7:0] code);
    logic [7:0] ch;
    logic       hit;
    int         k;
    if (cur_mode == MODE_GRANTED) return EV_NONE;
    ch = code;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ch = ch + CH_CASE;
    k = word_idx;
    if (k < 6 && ch == FORGOT_TEXT[47-8*k -: 8]) begin
      word_idx++;
      if (word_idx == 6) begin
        word_idx = 0;
        fail_cnt = 4'd0;
        cur_mode = MODE_IDLE;
        entry_len = 0;
        led_restart(1'b0);
        return EV_RESET;
      end
      return EV_NONE;
    end
    // a mismatching letter is not retried as the first letter
    word_idx = 0;
    if (cur_mode == MODE_LOCKED || ch < CH_ZERO || ch > CH_NINE) return EV_NONE;
    entry[entry_len] = ch[3:0];
    entry_len++;
    if (entry_len < DIGITS) return EV_DIGIT;
    entry_len = 0;
    hit = 1'b1;
    for (k = 0; k < DIGITS; k++)
      if (entry[k] != pw_digit(k)) hit = 1'b0;
    if (hit) begin
      cur_mode = MODE_GRANTED;
      led_restart(1'b1);
      return EV_GRANTED;
    end
    if (fail_cnt != 4'hf) fail_cnt++;
    if (fail_cnt >= max_fail_cfg) begin
      cur_mode = MODE_LOCKED;
      led_restart(1'b1);
      return EV_WRONG_LOCKED;
    end
    return EV_WRONG;
  endfunction

  task automatic predict_item(input logic action, input logic [7:0] code);
    lock_result_t r;
    r.ev = EV_NONE;
    if (action) led_tick();
    else r.ev = take_char(code);
    r.mode = cur_mode;
    r.led = led_lvl;
    r.fails = fail_cnt;
    expected_q.push_back(r);
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      CFG_PASSWORD:     pw_cfg = data;
      CFG_MAX_FAILURES: max_fail_cfg = data[3:0];
      CFG_LOCKED_HALF:  lock_half_cfg = data[7:0];
      CFG_GRANTED_HALF: grant_half_cfg = data[7:0];
      CFG_GRANTED_BLNK: grant_blinks_cfg = data[2:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("mismatch at result %0d: %s", results_checked, what);
  endtask

  task automatic check_result(input lock_result_t exp_r);
    if (out_event_res !== exp_r.ev)
      report_mismatch($sformatf("event %0d, want %0d", out_event_res, exp_r.ev));
    if (out_mode !== exp_r.mode)
      report_mismatch($sformatf("mode %0d, want %0d", out_mode, exp_r.mode));
    if (out_led_on !== exp_r.led)
      report_mismatch($sformatf("led %0d, want %0d", out_led_on, exp_r.led));
    if (out_failure_count !== exp_r.fails)
      report_mismatch($sformatf("failures %0d, want %0d", out_failure_count, exp_r.fails));
    case (exp_r.ev)
      EV_GRANTED:      grants_seen++;
      EV_WRONG_LOCKED: lockouts_seen++;
      EV_WRONG:        wrongs_seen++;
      EV_RESET:        resets_seen++;
      default: ;
    endcase
  endtask

  // monitor, predictor hookup and watchdog
  always @(posedge clk) begin
    item_taken <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = expected_q.pop_front();
          check_result(want);
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        predict_item(in_action, in_char_code);
        items_sent++;
      end
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if ((expected_q.size() != 0 || items_sent != items_queued || cfg_valid) &&
          !(in_valid && in_ready) && !(out_valid && out_ready) && !(cfg_valid && cfg_ready)) begin
        stuck_cycles++;
      end else begin
        stuck_cycles = 0;
      end
      if (stuck_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", stuck_cycles);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && (!in_valid || item_taken)) begin
      if (key_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        next_key = key_q.pop_front();
        in_valid <= 1'b1;
        in_action <= next_key.action;
        in_char_code <= next_key.code;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic push_item(input logic action, input logic [7:0] code);
    key_item_t k;
    k.action = action;
    k.code = code;
    key_q.push_back(k);
    items_queued++;
  endtask

  task automatic push_char(input logic [7:0] c);
    push_item(1'b0, c);
  endtask

  task automatic push_ticks(input int n);
    int i;
    for (i = 0; i < n; i++) push_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_word(input bit broken);
    logic [7:0] c;
    int         cut;
    int         i;
    cut = broken ? $urandom_range(5) : 6;
    for (i = 0; i < 6; i++) begin
      c = FORGOT_TEXT[47-8*i -: 8];
      if ($urandom_range(1)) c = c ^ CH_CASE;
      if (i == cut) c = 8'($urandom_range(255));
      push_char(c);
    end
  endtask

  task automatic push_random_seq();
    int pick;
    int i;
    pick = $urandom_range(99);
    if (pick < 40) begin
      for (i = 0; i < DIGITS; i++) push_char(CH_ZERO + 8'($urandom_range(9)));
    end else if (pick < 55) begin
      push_word($urandom_range(99) < 20);
    end else if (pick < 80) begin
      push_ticks($urandom_range(1, 12));
    end else begin
      push_char(8'($urandom_range(255)));
    end
  endtask

  task automatic wait_drained();
    while (items_sent != items_queued || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int start;
    start = items_queued;
    while (items_queued - start < n) push_random_seq();
    wait_drained();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_config(input logic [15:0] pw, input logic [3:0] maxf,
                            input logic [7:0] lhalf, input logic [7:0] ghalf,
                            input logic [2:0] gblinks);
    write_reg(CFG_PASSWORD, pw);
    write_reg(CFG_MAX_FAILURES, {12'd0, maxf});
    write_reg(CFG_LOCKED_HALF, {8'd0, lhalf});
    write_reg(CFG_GRANTED_HALF, {8'd0, ghalf});
    write_reg(CFG_GRANTED_BLNK, {13'd0, gblinks});
  endtask

  task automatic set_idle(input int gap, input int stall);
    gap_pct = gap;
    stall_pct = stall;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_char_code = 8'd0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = 16'd0;
    item_taken = 1'b0;
    cfg_taken = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    items_queued = 0;
    items_sent = 0;
    results_checked = 0;
    cfg_writes = 0;
    err_count = 0;
    stuck_cycles = 0;
    grants_seen = 0;
    lockouts_seen = 0;
    wrongs_seen = 0;
    resets_seen = 0;
    cur_mode = MODE_IDLE;
    fail_cnt = 4'd0;
    for (int i = 0; i < DIGITS; i++) entry[i] = 4'd0;
    entry_len = 0;
    word_idx = 0;
    led_tmr = 8'd0;
    led_lvl = 1'b0;
    blink_cnt = 3'd0;
    pw_cfg = 16'h1234;
    max_fail_cfg = 4'd3;
    lock_half_cfg = 8'd50;
    grant_half_cfg = 8'd30;
    grant_blinks_cfg = 3'd3;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed, default configuration
    push_ticks(1);
    push_char(8'h00);
    push_char(8'hff);
    push_text("Fof");
    push_text("1235");
    push_text(":/");
    push_text("9099");
    push_text("0000");
    push_ticks(1);
    push_char("5");
    push_text("FORGOT");
    wait_drained();

    set_config(16'h12a4, 4'd1, 8'd1, 8'd1, 3'd0);
    set_idle(0, 0);
    run_random(115);

    set_config(16'h0f00, 4'd15, 8'd255, 8'd255, 3'd7);
    set_idle(71, 0);
    run_random(115);

    set_config(16'h9999, 4'd2, 8'd3, 8'd2, 3'd5);
    set_idle(0, 71);
    run_random(115);

    set_config(16'h00a0, 4'd4, 8'd2, 8'd3, 3'd1);
    set_idle(35, 35);
    run_random(115);

    // grant: terminal, so it comes last
    set_config(16'h0000, 4'd15, 8'd1, 8'd255, 3'd0);
    push_char("#");
    push_text("forGOT");
    push_text("0000");
    push_ticks(3);
    push_text("forgot7");
    push_ticks(2);
    wait_drained();

    write_reg(CFG_GRANTED_BLNK, 16'd7);
    write_reg(CFG_GRANTED_HALF, 16'd1);
    push_ticks(20);
    run_random(40);

    write_reg(CFG_GRANTED_BLNK, 16'd2);
    write_reg(CFG_GRANTED_HALF, 16'd2);
    push_ticks(6);
    wait_drained();

    repeat (10) @(posedge clk);
    $display("checked %0d results from %0d transactions across %0d register writes",
             results_checked, items_sent, cfg_writes);
    $display("seen: %0d wrong entries, %0d lockouts, %0d reset words, %0d grants",
             wrongs_seen, lockouts_seen, resets_seen, grants_seen);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
